@@ rtl/core/obd_pkg.sv @@
// ----------------------------------------------------------------------------
// obd_pkg
// shared constants, payload types and command format of the bucket distributor
// ----------------------------------------------------------------------------
package obd_pkg;

    localparam int BUCKETS_DEF   = 8;
    localparam int MAX_SLOTS_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam int KEY_W     = 6;
    localparam int PAYLOAD_W = 32;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 4;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 4'd6;

    typedef logic        [KEY_W-1:0]     t_key;
    typedef logic signed [PAYLOAD_W-1:0] t_payload;

    typedef struct packed {
        logic             wr;
        logic             fin;
        logic             ovf;
        logic [IDX_W-1:0] bkt;
        logic [IDX_W-1:0] slot;
        logic [CFG_W-1:0] cap;
        t_key             key;
        t_payload         payload;
    } t_cmd;

    typedef struct packed {
        t_key     key;
        t_payload payload;
    } t_entry;

    typedef struct packed {
        logic             is_dummy;
        t_key             out_key;
        t_payload         out_payload;
        logic [IDX_W-1:0] bucket_index;
        logic [IDX_W-1:0] slot_index;
        logic             overflowed;
        logic             last_of_chunk;
    } t_result;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

@@ rtl/core/obd_intf.sv @@
// ----------------------------------------------------------------------------
// obd_intf
// valid/ready channels for input pairs and padded slot results
// ----------------------------------------------------------------------------
interface obd_item_if;
    logic              valid;
    logic              ready;
    obd_pkg::t_key     perm_key;
    obd_pkg::t_payload payload;

    modport source (output valid, output perm_key, output payload, input ready);
    modport sink   (input valid, input perm_key, input payload, output ready);
endinterface

interface obd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          is_dummy;
    obd_pkg::t_key                 out_key;
    obd_pkg::t_payload             out_payload;
    logic [obd_pkg::IDX_W-1:0]     bucket_index;
    logic [obd_pkg::IDX_W-1:0]     slot_index;
    logic                          overflowed;
    logic                          last_of_chunk;

    modport source (output valid, output is_dummy, output out_key, output out_payload,
                    output bucket_index, output slot_index, output overflowed,
                    output last_of_chunk, input ready);
    modport sink   (input valid, input is_dummy, input out_key, input out_payload,
                    input bucket_index, input slot_index, input overflowed,
                    input last_of_chunk, output ready);
endinterface

@@ rtl/core/oblivious_bucket_distributor.sv @@
// ----------------------------------------------------------------------------
// oblivious_bucket_distributor
// distribution phase of a melbourne shuffle, one chunk of pairs at a time
//
//   channel    dir  handshake            payload
//   i_item     in   valid/ready          perm_key, payload
//   o_result   out  valid/ready          is_dummy, out_key, out_payload,
//                                        bucket_index, slot_index, overflowed,
//                                        last_of_chunk
//   cfg        in   i_cfg_wr_en          i_cfg_wr_data (slots_in_use)
//
// the front handles an item combinationally; the chunk's last item starts
// a sweep of BUCKETS * cap results (cap: slots_in_use held to 1..MAX_SLOTS)
// at one per cycle unless o_result stalls, set by the single read port of
// the bucket store, whose read data is registered
// the front stalls only when the command queue is full during a sweep
// synchronous reset clears counters and flags, no clearing pass of the store
// ----------------------------------------------------------------------------
module oblivious_bucket_distributor #(
    parameter int BUCKETS   = obd_pkg::BUCKETS_DEF,
    parameter int MAX_SLOTS = obd_pkg::MAX_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [obd_pkg::CFG_W-1:0] i_cfg_wr_data,
    obd_item_if.sink                  i_item,
    obd_result_if.source              o_result
);

    logic          front_valid;
    logic          front_ready;
    obd_pkg::t_cmd front_cmd;
    logic          back_valid;
    logic          back_ready;
    obd_pkg::t_cmd back_cmd;

    obd_front #(
        .BUCKETS   (BUCKETS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .o_cmd_valid   (front_valid),
        .i_cmd_ready   (front_ready),
        .o_cmd         (front_cmd)
    );

    obd_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (back_cmd)
    );

    obd_back #(
        .BUCKETS   (BUCKETS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_result    (o_result)
    );

endmodule

@@ rtl/core/obd_front.sv @@
// ----------------------------------------------------------------------------
// obd_front
// takes pairs, finds their bucket, tracks fill and overflow, issues commands
// ----------------------------------------------------------------------------
module obd_front #(
    parameter int BUCKETS   = obd_pkg::BUCKETS_DEF,
    parameter int MAX_SLOTS = obd_pkg::MAX_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [obd_pkg::CFG_W-1:0] i_cfg_wr_data,
    obd_item_if.sink                  i_item,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output obd_pkg::t_cmd             o_cmd
);

    localparam int BW      = $clog2(BUCKETS);
    localparam int CW      = $clog2(MAX_SLOTS + 1);
    localparam int KEY_LIM = BUCKETS * BUCKETS;

    logic [obd_pkg::CFG_W-1:0] r_slots;
    logic [CW-1:0]             r_fill [BUCKETS];
    logic [BW-1:0]             r_taken;
    logic                      r_ovf;

    logic [CW-1:0] cap;
    logic [BW-1:0] bkt;
    logic          in_range;
    logic [CW-1:0] fill_cur;
    logic          accept;
    logic          do_ins;
    logic          do_ovf;
    logic          last;

    always_comb begin
        if (r_slots == '0) begin
            cap = CW'(1);
        end else if (r_slots > obd_pkg::CFG_W'(MAX_SLOTS)) begin
            cap = CW'(MAX_SLOTS);
        end else begin
            cap = CW'(r_slots);
        end
    end

    // bucket is key / BUCKETS through threshold compares
    always_comb begin
        bkt = '0;
        for (int j = 1; j < BUCKETS; j++) begin
            if ({1'b0, i_item.perm_key} >= (obd_pkg::KEY_W + 1)'(j * BUCKETS)) begin
                bkt = BW'(j);
            end
        end
    end

    assign in_range = {1'b0, i_item.perm_key} < (obd_pkg::KEY_W + 1)'(KEY_LIM);
    assign fill_cur = r_fill[bkt];
    assign accept   = i_item.valid && i_item.ready;
    assign do_ins   = !r_ovf && in_range && (fill_cur < cap);
    assign do_ovf   = !r_ovf && in_range && (fill_cur >= cap);
    assign last     = (r_taken == BW'(BUCKETS - 1));

    assign i_item.ready = i_cmd_ready;
    assign o_cmd_valid  = accept && (do_ins || last);

    always_comb begin
        o_cmd.wr      = do_ins;
        o_cmd.fin     = last;
        o_cmd.ovf     = r_ovf || do_ovf;
        o_cmd.bkt     = obd_pkg::IDX_W'(bkt);
        o_cmd.slot    = obd_pkg::IDX_W'(fill_cur);
        o_cmd.cap     = obd_pkg::CFG_W'(cap);
        o_cmd.key     = i_item.perm_key;
        o_cmd.payload = i_item.payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= obd_pkg::SLOTS_RESET;
        end else if (i_cfg_wr_en) begin
            r_slots <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (accept) begin
            if (last) begin
                r_taken <= '0;
                r_ovf   <= 1'b0;
                for (int i = 0; i < BUCKETS; i++) begin
                    r_fill[i] <= '0;
                end
            end else begin
                r_taken <= r_taken + BW'(1);
                if (do_ovf) begin
                    r_ovf <= 1'b1;
                end
                if (do_ins) begin
                    r_fill[bkt] <= fill_cur + CW'(1);
                end
            end
        end
    end

endmodule

@@ rtl/core/obd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// obd_cmd_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module obd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  obd_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output obd_pkg::t_cmd o_pop_cmd
);

    localparam int DEPTH = obd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    obd_pkg::t_cmd r_buf [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = (r_cnt != (PW + 1)'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_buf[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (PW + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (PW + 1)'(1);
            end
        end
    end

endmodule

@@ rtl/core/obd_back.sv @@
// ----------------------------------------------------------------------------
// obd_back
// writes pairs into the bucket store and sweeps out the padded buckets
// ----------------------------------------------------------------------------
module obd_back #(
    parameter int BUCKETS   = obd_pkg::BUCKETS_DEF,
    parameter int MAX_SLOTS = obd_pkg::MAX_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  obd_pkg::t_cmd i_cmd,
    obd_result_if.source  o_result
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int AW    = BW + SW;
    localparam int DEPTH = BUCKETS << SW;

    typedef struct packed {
        logic                      is_dummy;
        logic [obd_pkg::IDX_W-1:0] bucket_index;
        logic [obd_pkg::IDX_W-1:0] slot_index;
        logic                      overflowed;
        logic                      last_of_chunk;
    } t_meta;

    obd_pkg::t_back_state r_state;
    obd_pkg::t_back_state n_state;

    obd_pkg::t_entry mem [DEPTH];
    obd_pkg::t_entry r_rdata;

    logic [CW-1:0] r_fill [BUCKETS];
    logic [BW-1:0] r_bk;
    logic [BW-1:0] n_bk;
    logic [SW-1:0] r_sl;
    logic [SW-1:0] n_sl;
    logic [CW-1:0] r_cap;
    logic [CW-1:0] n_cap;
    logic          r_ovf;
    logic          n_ovf;

    logic  r_rd_vld;
    t_meta r_rd_meta;
    t_meta rd_meta;

    obd_pkg::t_result r_ob [2];
    logic             r_ob_wp;
    logic             r_ob_rp;
    logic [1:0]       r_ob_cnt;

    obd_pkg::t_result res_in;
    logic             ob_pop;
    logic             issue;
    logic             mem_we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic             sl_end;
    logic             bk_end;
    logic             sweep_done;

    assign ob_pop = o_result.valid && o_result.ready;
    assign sl_end = (CW'(r_sl) == r_cap - CW'(1));
    assign bk_end = (r_bk == BW'(BUCKETS - 1));
    assign waddr  = {i_cmd.bkt[BW-1:0], i_cmd.slot[SW-1:0]};
    assign raddr  = {r_bk, r_sl};

    always_comb begin
        n_state     = r_state;
        n_bk        = r_bk;
        n_sl        = r_sl;
        n_cap       = r_cap;
        n_ovf       = r_ovf;
        o_cmd_ready = 1'b0;
        mem_we      = 1'b0;
        issue       = 1'b0;
        sweep_done  = 1'b0;
        case (r_state)
            obd_pkg::BK_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    mem_we = i_cmd.wr;
                    if (i_cmd.fin) begin
                        n_state = obd_pkg::BK_EMIT;
                        n_bk    = '0;
                        n_sl    = '0;
                        n_cap   = CW'(i_cmd.cap);
                        n_ovf   = i_cmd.ovf;
                    end
                end
            end
            obd_pkg::BK_EMIT: begin
                issue = ((r_ob_cnt + 2'(r_rd_vld)) <= (2'd1 + 2'(ob_pop)));
                if (issue) begin
                    if (sl_end) begin
                        n_sl = '0;
                        if (bk_end) begin
                            sweep_done = 1'b1;
                            n_state    = obd_pkg::BK_IDLE;
                        end else begin
                            n_bk = r_bk + BW'(1);
                        end
                    end else begin
                        n_sl = r_sl + SW'(1);
                    end
                end
            end
            default: begin
                n_state = obd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_meta.is_dummy      = !(CW'(r_sl) < r_fill[r_bk]);
        rd_meta.bucket_index  = obd_pkg::IDX_W'(r_bk);
        rd_meta.slot_index    = obd_pkg::IDX_W'(r_sl);
        rd_meta.overflowed    = r_ovf;
        rd_meta.last_of_chunk = sl_end && bk_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obd_pkg::BK_IDLE;
            r_bk    <= '0;
            r_sl    <= '0;
            r_cap   <= CW'(1);
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bk    <= n_bk;
            r_sl    <= n_sl;
            r_cap   <= n_cap;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (sweep_done) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (mem_we) begin
            r_fill[i_cmd.bkt[BW-1:0]] <= CW'(i_cmd.slot) + CW'(1);
        end
    end

    // bucket store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= '{key: i_cmd.key, payload: i_cmd.payload};
        end
        if (issue) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_meta <= rd_meta;
        end
    end

    always_comb begin
        res_in.is_dummy      = r_rd_meta.is_dummy;
        res_in.out_key       = r_rd_meta.is_dummy ? '0 : r_rdata.key;
        res_in.out_payload   = r_rd_meta.is_dummy ? '0 : r_rdata.payload;
        res_in.bucket_index  = r_rd_meta.bucket_index;
        res_in.slot_index    = r_rd_meta.slot_index;
        res_in.overflowed    = r_rd_meta.overflowed;
        res_in.last_of_chunk = r_rd_meta.last_of_chunk;
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_ob[r_ob_wp] <= res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (r_rd_vld && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (ob_pop && !r_rd_vld) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    assign o_result.valid         = (r_ob_cnt != '0);
    assign o_result.is_dummy      = r_ob[r_ob_rp].is_dummy;
    assign o_result.out_key       = r_ob[r_ob_rp].out_key;
    assign o_result.out_payload   = r_ob[r_ob_rp].out_payload;
    assign o_result.bucket_index  = r_ob[r_ob_rp].bucket_index;
    assign o_result.slot_index    = r_ob[r_ob_rp].slot_index;
    assign o_result.overflowed    = r_ob[r_ob_rp].overflowed;
    assign o_result.last_of_chunk = r_ob[r_ob_rp].last_of_chunk;

endmodule
